FILE: rtl/fhss_pkg.sv
// fhss_pkg: shared types and constants for the hop sequence generator
// used by fhss_div and fhss_hop_sequence_generator
package fhss_pkg;

    localparam int MAX_CHANNELS = 64;

    localparam logic [31:0] DEFAULT_SEED = 32'h6D2B79F5;
    localparam logic [31:0] RESET_BASE = 32'd490500000;
    localparam logic [31:0] RESET_SPACING = 32'd1000000;
    localparam logic [15:0] RESET_DWELL = 16'd10;

    localparam logic OP_BIND = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_BIND_OK = 2'd0;
    localparam logic [1:0] ST_BIND_REJ = 2'd1;
    localparam logic [1:0] ST_QUERY_OK = 2'd2;
    localparam logic [1:0] ST_NOT_PAIRED = 2'd3;

    localparam logic CFG_BASE = 1'b0;
    localparam logic CFG_SPACING = 1'b1;

    // divider handshake
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

endpackage

FILE: rtl/fhss_hop_sequence_generator.sv
// fhss_hop_sequence_generator: top level of the hop sequencer
// depends on fhss_pkg and fhss_div
//
// A bind request (operation 0) checks the channel count (1..MAX_CHANNELS) and
// slot length (nonzero), seeds a xorshift32 generator and shuffles channel
// numbers into an internal hop table. A query request (operation 1) returns
// slot = (elapsed_ms / slot length) mod count, the channel at that slot and
// base + channel * spacing. One request is worked at a time. All division runs
// through a single bit-serial divider, one bit a cycle. A bind fills the table
// at one channel a cycle, then each shuffle step runs an xorshift step, a
// modulo start, the modulo, a read and a swap; a query runs two 32-step
// divides and a 6-step shift-add multiply before its result is valid. A
// rejected bind or an unpaired query has its result valid the cycle after the
// request. Results sit in an output register so the next request can be taken
// as soon as one result is out.
module fhss_hop_sequence_generator (
    input  logic        aclk,
    input  logic        aresetn,
    // request: tdata = {elapsed_ms, slot_length_ms, channel_count, seed}
    //   bits 31:0 seed, 39:32 channel_count, 55:40 slot_length_ms, 87:56 elapsed_ms
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        s_tuser,    // operation
    // result: bits 1:0 status, 7:2 slot_index, 13:8 channel_index, 45:14 frequency_hz
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,
    // configuration write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import fhss_pkg::*;

    localparam int AW = $clog2(MAX_CHANNELS);
    localparam int NW = $clog2(MAX_CHANNELS + 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_PRNG = 4'd2;
    localparam logic [3:0] S_MOD = 4'd3;
    localparam logic [3:0] S_RDJ = 4'd4;
    localparam logic [3:0] S_SWAP = 4'd5;
    localparam logic [3:0] S_QDIV = 4'd6;
    localparam logic [3:0] S_QMOD = 4'd7;
    localparam logic [3:0] S_QRD = 4'd8;
    localparam logic [3:0] S_QMUL = 4'd9;
    localparam logic [3:0] S_OUT = 4'd10;
    localparam logic [3:0] S_DIVW = 4'd11;
    localparam logic [3:0] S_QRD2 = 4'd12;

    logic [3:0]    state_reg, state_next;
    logic [3:0]    ret_reg, ret_next;
    logic [31:0]   base_reg, spacing_reg;
    logic [31:0]   prng_reg, prng_next;
    logic [NW-1:0] active_reg, active_next;
    logic [15:0]   dwell_reg, dwell_next;
    logic          paired_reg, paired_next;
    logic [NW-1:0] idx_reg, idx_next;
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   mpl_reg, mpl_next;
    logic [5:0]    mcnt_reg, mcnt_next;
    logic [AW-1:0] slot_reg, slot_next;
    logic [AW-1:0] j_reg, j_next;
    logic [5:0]    ch_reg, ch_next;
    logic          ov_reg, ov_next;
    logic [47:0]   out_reg, out_next;

    // divider
    div_ctl_t      dctl;
    div_sts_t      dsts;
    logic [31:0]   div_a;
    logic [15:0]   div_b;
    logic [31:0]   dq;
    logic [15:0]   dr;

    // hop table, one write port and one read port
    logic [5:0]    hop_mem [MAX_CHANNELS];
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [5:0]    wdata, rdata_reg;
    logic [5:0]    vi_reg, vi_next;

    logic [NW-1:0] cnt_in;
    logic          bad;

    fhss_div #(.DW(32), .RW(16)) u_div (
        .aclk(aclk), .aresetn(aresetn), .ctl(dctl), .dividend(div_a),
        .divisor(div_b), .sts(dsts), .quotient(dq), .remainder(dr)
    );

    always_ff @(posedge aclk) begin
        if (we) hop_mem[waddr] <= wdata;
        rdata_reg <= hop_mem[raddr];
    end

    assign s_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_tvalid = ov_reg;
    assign m_tdata = out_reg;
    assign cfg_ready = 1'b1;

    assign cnt_in = NW'(s_tdata[39:32]);
    assign bad = (s_tdata[39:32] == 8'd0) || (s_tdata[39:32] > 8'(MAX_CHANNELS))
                 || (s_tdata[55:40] == 16'd0);

    function automatic logic [31:0] xs(input logic [31:0] v);
        logic [31:0] x;
        x = v ^ (v << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        return x;
    endfunction

    // sequencer
    always_comb begin
        state_next = state_reg;
        ret_next = ret_reg;
        prng_next = prng_reg;
        active_next = active_reg;
        dwell_next = dwell_reg;
        paired_next = paired_reg;
        idx_next = idx_reg;
        acc_next = acc_reg;
        mpl_next = mpl_reg;
        mcnt_next = mcnt_reg;
        slot_next = slot_reg;
        j_next = j_reg;
        ch_next = ch_reg;
        vi_next = vi_reg;
        ov_next = ov_reg;
        out_next = out_reg;
        dctl.start = 1'b0;
        div_a = acc_reg;
        div_b = 16'd1;
        we = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = 6'(idx_reg);
        raddr = j_reg;
        if (ov_reg && m_tready) ov_next = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    if (s_tuser == OP_BIND) begin
                        if (bad) begin
                            out_next = {46'd0, ST_BIND_REJ};
                            ov_next = 1'b1;
                        end else begin
                            active_next = cnt_in;
                            dwell_next = s_tdata[55:40];
                            prng_next = (s_tdata[31:0] != 32'd0) ? s_tdata[31:0]
                                                                 : DEFAULT_SEED;
                            idx_next = '0;
                            paired_next = 1'b1;
                            state_next = S_INIT;
                        end
                    end else if (!paired_reg) begin
                        out_next = {46'd0, ST_NOT_PAIRED};
                        ov_next = 1'b1;
                    end else begin
                        acc_next = s_tdata[87:56];
                        state_next = S_QDIV;
                    end
                end
            end
            // identity fill
            S_INIT: begin
                we = 1'b1;
                if (idx_reg == active_reg - 1'b1) begin
                    state_next = S_PRNG;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            // xorshift step then modulo (i+1); at i = 0 the bind completes
            S_PRNG: begin
                if (idx_reg == '0) begin
                    out_next = {46'd0, ST_BIND_OK};
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end else begin
                    prng_next = xs(prng_reg);
                    state_next = S_MOD;
                end
            end
            S_MOD: begin
                dctl.start = 1'b1;
                div_a = prng_reg;
                div_b = 16'(idx_reg) + 16'd1;
                ret_next = S_RDJ;
                state_next = S_DIVW;
            end
            S_DIVW: begin
                div_b = 16'd1;
                if (dsts.done) state_next = ret_reg;
            end
            S_RDJ: begin
                j_next = dr[AW-1:0];
                raddr = idx_reg[AW-1:0];
                state_next = S_SWAP;
            end
            // read i captured, now j; write i, then j
            S_SWAP: begin
                raddr = j_reg;
                if (mcnt_reg == 6'd0) begin
                    vi_next = rdata_reg;
                    mcnt_next = 6'd1;
                end else if (mcnt_reg == 6'd1) begin
                    mcnt_next = 6'd2;
                end else if (mcnt_reg == 6'd2) begin
                    we = 1'b1;
                    waddr = idx_reg[AW-1:0];
                    wdata = rdata_reg;
                    mcnt_next = 6'd3;
                end else begin
                    we = 1'b1;
                    waddr = j_reg;
                    wdata = vi_reg;
                    mcnt_next = 6'd0;
                    idx_next = idx_reg - 1'b1;
                    state_next = S_PRNG;
                end
            end
            // elapsed / dwell
            S_QDIV: begin
                dctl.start = 1'b1;
                div_a = acc_reg;
                div_b = dwell_reg;
                ret_next = S_QMOD;
                state_next = S_DIVW;
            end
            S_QMOD: begin
                dctl.start = 1'b1;
                div_a = dq;
                div_b = 16'(active_reg);
                ret_next = S_QRD;
                state_next = S_DIVW;
            end
            S_QRD: begin
                slot_next = dr[AW-1:0];
                raddr = dr[AW-1:0];
                state_next = S_QRD2;
            end
            S_QRD2: begin
                raddr = slot_reg;
                ch_next = rdata_reg;
                acc_next = base_reg;
                mpl_next = spacing_reg;
                mcnt_next = 6'd0;
                state_next = S_QMUL;
            end
            // shift-add multiply, one bit of channel per cycle
            S_QMUL: begin
                if (ch_reg[mcnt_reg[2:0]] && mcnt_reg < 6'd6) acc_next = acc_reg + mpl_reg;
                mpl_next = {mpl_reg[30:0], 1'b0};
                mcnt_next = mcnt_reg + 1'b1;
                if (mcnt_reg == 6'd5) begin
                    mcnt_next = 6'd0;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                out_next = {2'd0, acc_reg, ch_reg, 6'(slot_reg), ST_QUERY_OK};
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            prng_reg <= '0;
            active_reg <= '0;
            dwell_reg <= RESET_DWELL;
            paired_reg <= 1'b0;
            ov_reg <= 1'b0;
            mcnt_reg <= '0;
            base_reg <= RESET_BASE;
            spacing_reg <= RESET_SPACING;
        end else begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            prng_reg <= prng_next;
            active_reg <= active_next;
            dwell_reg <= dwell_next;
            paired_reg <= paired_next;
            ov_reg <= ov_next;
            mcnt_reg <= mcnt_next;
            if (cfg_valid && cfg_index == CFG_BASE) base_reg <= cfg_data;
            if (cfg_valid && cfg_index == CFG_SPACING) spacing_reg <= cfg_data;
        end
        idx_reg <= idx_next;
        acc_reg <= acc_next;
        mpl_reg <= mpl_next;
        slot_reg <= slot_next;
        j_reg <= j_next;
        ch_reg <= ch_next;
        vi_reg <= vi_next;
        out_reg <= out_next;
    end

endmodule

FILE: rtl/fhss_div.sv
// fhss_div: bit-serial restoring divider, one quotient bit per cycle
// depends on fhss_pkg for the control and status structs
module fhss_div #(
    parameter int DW = 32,
    parameter int RW = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fhss_pkg::div_ctl_t  ctl,
    input  logic [DW-1:0]       dividend,
    input  logic [RW-1:0]       divisor,
    output fhss_pkg::div_sts_t  sts,
    output logic [DW-1:0]       quotient,
    output logic [RW-1:0]       remainder
);
    import fhss_pkg::*;

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0] q_reg, q_next;
    logic [RW:0]   r_reg, r_next;
    logic [RW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [RW:0]   trial;
    logic [RW:0]   diff;

    // one shift-subtract step per cycle
    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg[RW-1:0], q_reg[DW-1]};
        diff = trial - {1'b0, d_reg};
        if (ctl.start) begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = CW'(DW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[RW]) begin
                r_next = diff;
                q_next = {q_reg[DW-2:0], 1'b1};
            end else begin
                r_next = trial;
                q_next = {q_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = q_reg;
    assign remainder = r_reg[RW-1:0];

endmodule

FILE: rtl/fhss_chk.sv
// fhss_chk: port-level checks for the hop sequence generator
// bound to fhss_hop_sequence_generator, uses fhss_pkg status codes
module fhss_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);
    import fhss_pkg::*;

    // no new request while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("request taken with result pending");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // non-query results carry zero fields
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != ST_QUERY_OK |-> m_tdata[47:2] == '0)
        else $error("nonzero fields on non-query result");

endmodule

bind fhss_hop_sequence_generator fhss_chk u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
